[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: transaction payloads,
// action and status codes, and the per-cell command word.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int OCC_W     = 7;

  localparam logic [1:0] ACT_PUSH_BACK  = 2'd0;
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic                    popped_valid;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } deq_out_t;

  // one-cycle command broadcast to every cell, already qualified
  typedef struct packed {
    logic push_back;
    logic push_front;
    logic pop_front;
    logic pop_back;
  } deq_cmd_t;

endpackage

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit entries built as a row of
// shifting cells. Each transaction pushes or pops at either end and returns
// one result with the popped entry, a status code and the occupancy.
// A transaction completes at once: the whole cell row shifts or loads
// in the accepting cycle and the result lands in the output register on the
// same edge, so one transaction is taken per cycle for as long as results
// are drained. in_stall rises only while a result is held by out_stall.
// Occupancy reports the entry count in its 7-bit field.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_out_t out_data
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                    accept;
  deq_cmd_t                cmd;
  logic [1:0]              status;
  logic                    popped_valid;
  logic [CNT_W-1:0]        count;
  logic [CNT_W+OCC_W-1:0]  count_ext;

  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic signed [VAL_W-1:0] cell_tail [DEPTH];
  logic [DEPTH-1:0]        cell_occ;
  logic signed [VAL_W-1:0] tail_value;
  logic signed [VAL_W-1:0] popped_value;

  logic                    out_valid_r, out_valid_nxt;
  deq_out_t                out_data_r, out_data_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (in_data.action),
    .full         (cell_occ[DEPTH-1]),
    .empty        (!cell_occ[0]),
    .cmd          (cmd),
    .status       (status),
    .popped_valid (popped_valid),
    .count        (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] l_data, r_data;
    logic                    l_occ, r_occ;

    if (i == 0) begin : g_first
      assign l_data = in_data.value;
      assign l_occ  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .push_value (in_data.value),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .tail_data  (cell_tail[i])
    );
  end

  // only the last occupied cell drives a non-zero tail
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | cell_tail[i];
    end
  end

  always_comb begin
    popped_value = '0;
    if (cmd.pop_front) begin
      popped_value = cell_data[0];
    end else if (cmd.pop_back) begin
      popped_value = tail_value;
    end
  end

  assign count_ext = {{OCC_W{1'b0}}, count};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.popped_value = popped_value;
      out_data_nxt.popped_valid = popped_valid;
      out_data_nxt.status       = status;
      out_data_nxt.occupancy    = count_ext[OCC_W-1:0];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_occ) == int'(u_ctrl.count_r))
    else $error("entry count disagrees with occupied cells");

  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_occ[DEPTH-1:1] & ~cell_occ[DEPTH-2:0]) == '0)
    else $error("occupied cells not contiguous from the front");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.popped_valid) |-> (out_data_r.status == ST_OK))
    else $error("popped entry reported with failing status");

  a_no_cmd_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> (cmd == '0))
    else $error("cell row command issued without a transaction");

endmodule

[rtl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Holds one entry and its occupied flag;
// shifts towards either neighbour, takes a back push when it is the first
// free cell, and offers its entry when it is the last occupied cell.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  deq_pkg::deq_cmd_t               cmd,
  input  logic signed [deq_pkg::VAL_W-1:0] push_value,
  input  logic signed [deq_pkg::VAL_W-1:0] left_data,
  input  logic                            left_occ,
  input  logic signed [deq_pkg::VAL_W-1:0] right_data,
  input  logic                            right_occ,
  output logic signed [deq_pkg::VAL_W-1:0] data,
  output logic                            occ,
  output logic signed [deq_pkg::VAL_W-1:0] tail_data
);
  import deq_pkg::*;

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic                    occ_r, occ_nxt;
  logic                    is_tail;

  assign is_tail = occ_r && !right_occ;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (cmd.push_front) begin
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (cmd.push_back) begin
      if (left_occ && !occ_r) begin
        data_nxt = push_value;
        occ_nxt  = 1'b1;
      end
    end else if (cmd.pop_front) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (cmd.pop_back) begin
      if (is_tail) begin
        occ_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign occ       = occ_r;
  assign tail_data = is_tail ? data_r : '0;

endmodule

[rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Decodes the requested action against the full and empty flags of the
// cell row, issues the cell command, reports status and keeps the count.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic              full,
  input  logic              empty,
  output deq_pkg::deq_cmd_t cmd,
  output logic [1:0]        status,
  output logic              popped_valid,
  output logic [CNT_W-1:0]  count
);
  import deq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             is_push;

  assign is_push = (action == ACT_PUSH_BACK) || (action == ACT_PUSH_FRONT);

  always_comb begin
    cmd       = '0;
    status    = ST_OK;
    count_nxt = count_r;
    if (is_push) begin
      if (full) begin
        status = ST_FULL;
      end else if (accept) begin
        cmd.push_back  = (action == ACT_PUSH_BACK);
        cmd.push_front = (action == ACT_PUSH_FRONT);
        count_nxt      = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end else if (accept) begin
        cmd.pop_front = (action == ACT_POP_FRONT);
        cmd.pop_back  = (action == ACT_POP_BACK);
        count_nxt     = count_r - CNT_W'(1);
      end
    end
  end

  assign popped_valid = cmd.pop_front || cmd.pop_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_nxt;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue. Pushes and pops at both
// ends are sent through the valid/stall input channel. A ring-buffer
// shadow of the queue predicts each result when its transaction is
// accepted, and every result is compared field by field in order. The
// tests cover empty pops and extreme values, fill-to-full and drain with
// refused pushes and pops, and a long random mix. Both channels see random
// idle gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  deq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_out_t out_data;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow ring buffer
  logic signed [VAL_W-1:0] shadow_mem [DEPTH];
  int       shadow_head  = 0;
  int       shadow_count = 0;
  deq_out_t pending_results [$];
  deq_out_t oldest_result;

  int error_count = 0;
  int cycle_count = 0;
  int mode_timer  = 0;
  int send_busy   = 1;
  int drain_busy  = 1;
  int stall_left  = 0;

  function automatic deq_out_t apply_action(deq_in_t item);
    deq_out_t r;
    r = '0;
    r.status = ST_OK;
    case (item.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (item.action == ACT_PUSH_BACK) begin
          shadow_mem[(shadow_head + shadow_count) % DEPTH] = item.value;
          shadow_count++;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_mem[shadow_head] = item.value;
          shadow_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = shadow_mem[shadow_head];
          r.popped_valid = 1'b1;
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = shadow_mem[(shadow_head + shadow_count - 1) % DEPTH];
          r.popped_valid = 1'b1;
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_busy == 0 || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 20);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // one transaction on the input channel, predicted on acceptance
  task automatic send_item(input logic [1:0] act, input logic signed [VAL_W-1:0] val);
    deq_in_t item;
    int      gap;
    item.action = act;
    item.value  = val;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_action(in_data));
  endtask

  task automatic send_push(input logic signed [VAL_W-1:0] val);
    send_item($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, val);
  endtask

  task automatic send_pop();
    send_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom());
  endtask

  task automatic test_empty_pops();
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, -32'sd1);
    send_item(ACT_POP_FRONT, 32'sh5555_5555);
  endtask

  task automatic test_extreme_values();
    send_item(ACT_PUSH_BACK,  32'sh8000_0000);
    send_item(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_item(ACT_PUSH_BACK,  '0);
    send_item(ACT_PUSH_FRONT, -32'sd1);
    send_item(ACT_PUSH_BACK,  32'sh5555_5555);
    send_item(ACT_PUSH_FRONT, 32'shAAAA_AAAA);
    send_item(ACT_POP_FRONT,  32'shAAAA_AAAA);
    send_item(ACT_POP_BACK,   '0);
    send_item(ACT_POP_BACK,   -32'sd1);
    send_item(ACT_POP_FRONT,  32'sh8000_0000);
    send_item(ACT_POP_FRONT,  32'sh7FFF_FFFF);
    send_item(ACT_POP_BACK,   32'sh5555_5555);
    send_item(ACT_POP_BACK,   '0);
    send_item(ACT_POP_FRONT,  '0);
  endtask

  task automatic test_fill_and_drain();
    while (shadow_count < DEPTH) send_push(pick_value());
    send_item(ACT_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_push($urandom());
    while (shadow_count > 0) send_pop();
    send_item(ACT_POP_BACK, $urandom());
    send_item(ACT_POP_FRONT, $urandom());
  endtask

  task automatic test_random_mix(input int n_items);
    int done;
    int phase_left;
    int push_bias;
    done       = 0;
    phase_left = 0;
    push_bias  = 50;
    while (done < n_items) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 160);
        case ($urandom_range(0, 2))
          0:       push_bias = 85;
          1:       push_bias = 15;
          default: push_bias = 50;
        endcase
      end
      if ($urandom_range(0, 99) < push_bias) begin
        send_push(pick_value());
      end else begin
        send_pop();
      end
      phase_left--;
      done++;
    end
  endtask

  // stretches with and without idling on each side
  always @(posedge clk) begin
    if (mode_timer == 0) begin
      mode_timer <= $urandom_range(100, 400);
      send_busy  <= ($urandom_range(0, 3) != 0);
      drain_busy <= ($urandom_range(0, 3) != 0);
    end else begin
      mode_timer <= mode_timer - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (drain_busy != 0 && $urandom_range(0, 99) < 20) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data), '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.popped_value !== oldest_result.popped_value)
          report_mismatch("popped_value", 64'(out_data.popped_value),
                          64'(oldest_result.popped_value));
        if (out_data.popped_valid !== oldest_result.popped_valid)
          report_mismatch("popped_valid", 64'(out_data.popped_valid),
                          64'(oldest_result.popped_valid));
        if (out_data.status !== oldest_result.status)
          report_mismatch("status", 64'(out_data.status), 64'(oldest_result.status));
        if (out_data.occupancy !== oldest_result.occupancy)
          report_mismatch("occupancy", 64'(out_data.occupancy),
                          64'(oldest_result.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pops();
    test_extreme_values();
    test_fill_and_drain();
    test_random_mix(500);
    test_fill_and_drain();
    test_random_mix(600);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
dv/tb_top.sv
